// ===== design/dcv_pkg.sv =====
package dcv_pkg;

   localparam int DELAY_BITS_DEF = 12;
   localparam int CSR_BITS       = 11;
   localparam int CSR_INDEX_BITS = 3;
   localparam int Q8_BITS        = 20;
   localparam int LATENCY        = 5;

   localparam logic [CSR_BITS-1:0] DELAY_LIMIT_RST       = 11'd200;
   localparam logic [CSR_BITS-1:0] FOLD_THRESHOLD_RST    = 11'd84;
   localparam logic [CSR_BITS-1:0] WRAP_PERIOD_RST       = 11'd52;
   localparam logic [CSR_BITS-1:0] REFOLD_WINDOW_RST     = 11'd25;
   localparam logic [CSR_BITS-1:0] CLUSTER_TOLERANCE_RST = 11'd4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DELAY_LIMIT       = 3'd0,
      REG_FOLD_THRESHOLD    = 3'd1,
      REG_WRAP_PERIOD       = 3'd2,
      REG_REFOLD_WINDOW     = 3'd3,
      REG_CLUSTER_TOLERANCE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CSR_BITS-1:0] delay_limit;
      logic [CSR_BITS-1:0] fold_threshold;
      logic [CSR_BITS-1:0] wrap_period;
      logic [CSR_BITS-1:0] refold_window;
      logic [CSR_BITS-1:0] cluster_tolerance;
   } cfg_type;

   // working width of a folded delay and of its distance from the reference
   function automatic int work_bits(input int delay_bits);
      return ((delay_bits > 12) ? delay_bits : 12) + 3;
   endfunction

endpackage

// ===== design/dcv_lane.sv =====
module dcv_lane
   import dcv_pkg::*;
#(
   parameter int DELAY_BITS = DELAY_BITS_DEF,
   localparam int W = work_bits(DELAY_BITS)
) (
   input  logic signed [DELAY_BITS-1:0] delay,
   input  logic signed [DELAY_BITS-1:0] reference_delay,
   input  cfg_type                      cfg,
   output logic signed [W-1:0]          value
);

   logic signed [W-1:0] th_w;
   logic signed [W-1:0] mx_w;
   logic signed [W-1:0] wp_w;
   logic signed [W-1:0] rw_w;
   logic signed [W-1:0] ref_w;
   logic signed [W-1:0] d0;
   logic signed [W-1:0] d1;
   logic signed [W-1:0] d2;
   logic signed [W-1:0] gap;
   logic signed [W-1:0] gap_mag;
   logic signed [W-1:0] off;
   logic signed [W-1:0] off_mag;

   function automatic logic signed [W-1:0] fold(
      input logic signed [W-1:0] d,
      input logic signed [W-1:0] th,
      input logic signed [W-1:0] mx,
      input logic signed [W-1:0] wp
   );
      logic signed [W-1:0] m;
      m = (d < 0) ? -d : d;
      if ((m > th) && (d < mx)) begin
         fold = (d > 0) ? d - wp : d + wp;
      end else begin
         fold = d;
      end
   endfunction

   assign th_w  = W'(cfg.fold_threshold);
   assign mx_w  = W'(cfg.delay_limit);
   assign wp_w  = W'(cfg.wrap_period);
   assign rw_w  = W'(cfg.refold_window);
   assign ref_w = W'(reference_delay);
   assign d0    = W'(delay);

   assign d1 = fold(d0, th_w, mx_w, wp_w);
   assign d2 = fold(d1, th_w, mx_w, wp_w);

   assign gap     = d2 - ref_w;
   assign gap_mag = (gap < 0) ? -gap : gap;
   assign off     = gap_mag - wp_w;
   assign off_mag = (off < 0) ? -off : off;

   always_comb begin
      value = d2;
      if (off_mag < rw_w) begin
         value = (d2 < ref_w) ? d2 + wp_w : d2 - wp_w;
      end
   end

endmodule

// ===== design/dcv_sort.sv =====
module dcv_sort
   import dcv_pkg::*;
#(
   parameter int DELAY_BITS = DELAY_BITS_DEF,
   localparam int W = work_bits(DELAY_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [W-1:0]          in_value [4],
   input  logic signed [DELAY_BITS-1:0] in_ref,
   output logic                         out_valid,
   output logic signed [W-1:0]          out_value [4],
   output logic signed [DELAY_BITS-1:0] out_ref
);

   logic signed [W-1:0] a [4];
   logic signed [W-1:0] b [4];
   logic signed [W-1:0] c [4];

   logic                         valid_ff;
   logic signed [W-1:0]          value_ff [4];
   logic signed [DELAY_BITS-1:0] ref_ff;

   always_comb begin
      a[0] = (in_value[1] < in_value[0]) ? in_value[1] : in_value[0];
      a[1] = (in_value[1] < in_value[0]) ? in_value[0] : in_value[1];
      a[2] = (in_value[3] < in_value[2]) ? in_value[3] : in_value[2];
      a[3] = (in_value[3] < in_value[2]) ? in_value[2] : in_value[3];

      b[0] = (a[2] < a[0]) ? a[2] : a[0];
      b[2] = (a[2] < a[0]) ? a[0] : a[2];
      b[1] = (a[3] < a[1]) ? a[3] : a[1];
      b[3] = (a[3] < a[1]) ? a[1] : a[3];

      c[0] = b[0];
      c[1] = (b[2] < b[1]) ? b[2] : b[1];
      c[2] = (b[2] < b[1]) ? b[1] : b[2];
      c[3] = b[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      value_ff <= c;
      ref_ff   <= in_ref;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_ref   = ref_ff;

endmodule

// ===== design/dcv_merge.sv =====
module dcv_merge
   import dcv_pkg::*;
#(
   parameter int DELAY_BITS = DELAY_BITS_DEF,
   localparam int W  = work_bits(DELAY_BITS),
   localparam int SW = W + 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  logic                         in_valid,
   input  logic signed [W-1:0]          in_value [4],
   input  logic signed [DELAY_BITS-1:0] in_ref,
   output logic                         out_strobe,
   output logic signed [Q8_BITS-1:0]    out_voted,
   output logic [1:0]                   out_count,
   output logic                         out_saturated
);

   typedef enum logic [1:0] {
      DEN_ONE,
      DEN_TWO,
      DEN_THREE,
      DEN_FOUR
   } den_type;

   localparam int MAG_BITS   = 13;
   localparam int M_BITS     = MAG_BITS + 8;
   localparam int PROD_BITS  = 2 * M_BITS;
   localparam int R_BITS     = Q8_BITS - 1;
   localparam int RECIP_SHIFT = M_BITS + 1;
   localparam logic [M_BITS-1:0] RECIP3 = M_BITS'(((1 << RECIP_SHIFT) + 2) / 3);

   logic signed [SW-1:0] s [4];
   logic signed [SW-1:0] ref_w;
   logic signed [SW-1:0] ref2;
   logic signed [SW-1:0] tol_w;
   logic signed [SW-1:0] mx_w;
   logic [2:0]           agree;
   logic [1:0]           count;
   logic signed [SW-1:0] lo;
   logic signed [SW-1:0] hi;
   logic signed [SW-1:0] lo_off;
   logic signed [SW-1:0] hi_off;
   logic signed [SW-1:0] lo_dist;
   logic signed [SW-1:0] hi_dist;
   logic signed [SW-1:0] near_dist [4];
   logic signed [SW-1:0] best_dist;
   logic [1:0]           best;
   logic signed [SW-1:0] num;
   den_type              den;

   logic                 v3_ff;
   logic signed [SW-1:0] num_ff;
   den_type              den3_ff;
   logic [1:0]           count3_ff;

   logic signed [SW-1:0]  mag;
   logic [CSR_BITS:0]     max1;
   logic [MAG_BITS:0]     lim;
   logic                  sat;
   logic [M_BITS-1:0]     m;
   logic [M_BITS-1:0]     x;
   logic [PROD_BITS-1:0]  prod;

   logic                 v4_ff;
   logic                 sat4_ff;
   logic                 neg4_ff;
   den_type              den4_ff;
   logic [1:0]           count4_ff;
   logic [M_BITS-1:0]    m4_ff;
   logic [R_BITS-1:0]    third4_ff;

   logic [R_BITS-1:0]        r;
   logic signed [Q8_BITS-1:0] q8;

   logic                      strobe_ff;
   logic signed [Q8_BITS-1:0] voted_ff;
   logic [1:0]                count_ff;
   logic                      saturated_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s[i] = SW'(in_value[i]);
      end
      ref_w = SW'(in_ref);
      ref2  = ref_w <<< 1;
      tol_w = SW'(cfg.cluster_tolerance);
      mx_w  = SW'(cfg.delay_limit);
      for (int i = 0; i < 3; i++) begin
         agree[i] = (s[i+1] - s[i]) <= tol_w;
      end
      count = 2'(agree[0]) + 2'(agree[1]) + 2'(agree[2]);

      lo      = s[0] + s[1];
      hi      = s[2] + s[3];
      lo_off  = lo - ref2;
      hi_off  = hi - ref2;
      lo_dist = ((lo_off < 0) ? -lo_off : lo_off) >>> 1;
      hi_dist = ((hi_off < 0) ? -hi_off : hi_off) >>> 1;

      for (int i = 0; i < 4; i++) begin
         near_dist[i] = (s[i] < ref_w) ? ref_w - s[i] : s[i] - ref_w;
      end
      best      = 2'd0;
      best_dist = near_dist[0];
      for (int i = 1; i < 4; i++) begin
         if (near_dist[i] < best_dist) begin
            best_dist = near_dist[i];
            best      = 2'(i);
         end
      end

      num = '0;
      den = DEN_ONE;
      case (count)
         2'd3: begin
            num = lo + hi;
            den = DEN_FOUR;
         end
         2'd2: begin
            if (!agree[0]) begin
               num = s[1] + hi;
               den = DEN_THREE;
            end else if (!agree[2]) begin
               num = lo + s[2];
               den = DEN_THREE;
            end else begin
               num = (lo_dist < hi_dist) ? lo : hi;
               den = DEN_TWO;
            end
         end
         2'd1: begin
            den = DEN_TWO;
            if (agree[2]) begin
               num = hi;
            end else if (agree[1]) begin
               num = s[1] + s[2];
            end else begin
               num = lo;
            end
         end
         default: begin
            if (ref_w != mx_w) begin
               num = s[best];
            end
         end
      endcase
   end

   always_comb begin
      mag  = (num_ff < 0) ? -num_ff : num_ff;
      max1 = {1'b0, cfg.delay_limit} + 1'b1;
      lim  = '0;
      case (den3_ff)
         DEN_ONE:   lim = (MAG_BITS+1)'(max1);
         DEN_TWO:   lim = (MAG_BITS+1)'(max1) << 1;
         DEN_THREE: lim = (MAG_BITS+1)'(max1) + ((MAG_BITS+1)'(max1) << 1);
         default:   lim = (MAG_BITS+1)'(max1) << 2;
      endcase
      sat  = mag >= SW'(lim);
      m    = {mag[MAG_BITS-1:0], 8'b0};
      x    = m + 1'b1;
      prod = PROD_BITS'(x) * PROD_BITS'(RECIP3);
   end

   always_comb begin
      r = '0;
      case (den4_ff)
         DEN_ONE:   r = m4_ff[R_BITS-1:0];
         DEN_TWO:   r = m4_ff[R_BITS:1];
         DEN_THREE: r = third4_ff;
         default:   r = m4_ff[R_BITS+1:2];
      endcase
      if (sat4_ff) begin
         q8 = {1'b0, cfg.delay_limit, 8'b0};
      end else if (neg4_ff) begin
         q8 = -{1'b0, r};
      end else begin
         q8 = {1'b0, r};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v3_ff     <= in_valid;
         v4_ff     <= v3_ff;
         strobe_ff <= v4_ff;
      end
      num_ff       <= num;
      den3_ff      <= den;
      count3_ff    <= count;
      sat4_ff      <= sat;
      neg4_ff      <= num_ff < 0;
      den4_ff      <= den3_ff;
      count4_ff    <= count3_ff;
      m4_ff        <= m;
      third4_ff    <= prod[RECIP_SHIFT+R_BITS-1:RECIP_SHIFT];
      voted_ff     <= q8;
      count_ff     <= count4_ff;
      saturated_ff <= sat4_ff;
   end

   assign out_strobe    = strobe_ff;
   assign out_voted     = voted_ff;
   assign out_count     = count_ff;
   assign out_saturated = saturated_ff;

endmodule

// ===== design/delay_consensus_vote.sv =====
// Channel    Handshake               Payload
// request    start / busy            req_delay_a..d, req_reference_delay
// response   rsp_strobe (one cycle)  rsp_voted_delay, rsp_agree_count, rsp_saturated
// csr write  csr_valid / csr_ready   csr_index, csr_data
//
// One transaction per cycle; busy stays low and csr_ready stays high.
// Pipeline stages: fold lanes, sort network, cluster select,
// reciprocal multiply for thirds, output register.
// Synchronous reset clears the pipeline valids and loads register defaults.
// The receiver cannot stall; each response shows for exactly one cycle.
module delay_consensus_vote
   import dcv_pkg::*;
#(
   parameter int DELAY_BITS = DELAY_BITS_DEF,
   localparam int W = work_bits(DELAY_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DELAY_BITS-1:0] req_delay_a,
   input  logic signed [DELAY_BITS-1:0] req_delay_b,
   input  logic signed [DELAY_BITS-1:0] req_delay_c,
   input  logic signed [DELAY_BITS-1:0] req_delay_d,
   input  logic signed [DELAY_BITS-1:0] req_reference_delay,
   output logic                         rsp_strobe,
   output logic signed [Q8_BITS-1:0]    rsp_voted_delay,
   output logic [1:0]                   rsp_agree_count,
   output logic                         rsp_saturated,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_BITS-1:0]          csr_data
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic signed [DELAY_BITS-1:0] lane_delay [4];
   logic signed [W-1:0]          lane_value [4];

   logic                         v1_ff;
   logic signed [W-1:0]          value1_ff [4];
   logic signed [DELAY_BITS-1:0] ref1_ff;

   logic                         v2;
   logic signed [W-1:0]          value2 [4];
   logic signed [DELAY_BITS-1:0] ref2;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_DELAY_LIMIT:       cfg_in.delay_limit       = csr_data;
            REG_FOLD_THRESHOLD:    cfg_in.fold_threshold    = csr_data;
            REG_WRAP_PERIOD:       cfg_in.wrap_period       = csr_data;
            REG_REFOLD_WINDOW:     cfg_in.refold_window     = csr_data;
            REG_CLUSTER_TOLERANCE: cfg_in.cluster_tolerance = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   assign lane_delay[0] = req_delay_a;
   assign lane_delay[1] = req_delay_b;
   assign lane_delay[2] = req_delay_c;
   assign lane_delay[3] = req_delay_d;

   for (genvar i = 0; i < 4; i++) begin : g_lane
      dcv_lane #(
         .DELAY_BITS(DELAY_BITS)
      ) u_lane (
         .delay          (lane_delay[i]),
         .reference_delay(req_reference_delay),
         .cfg            (cfg_ff),
         .value          (lane_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_limit       <= DELAY_LIMIT_RST;
         cfg_ff.fold_threshold    <= FOLD_THRESHOLD_RST;
         cfg_ff.wrap_period       <= WRAP_PERIOD_RST;
         cfg_ff.refold_window     <= REFOLD_WINDOW_RST;
         cfg_ff.cluster_tolerance <= CLUSTER_TOLERANCE_RST;
         v1_ff                    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         v1_ff  <= start && !busy;
      end
      value1_ff <= lane_value;
      ref1_ff   <= req_reference_delay;
   end

   dcv_sort #(
      .DELAY_BITS(DELAY_BITS)
   ) u_sort (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_ff),
      .in_value (value1_ff),
      .in_ref   (ref1_ff),
      .out_valid(v2),
      .out_value(value2),
      .out_ref  (ref2)
   );

   dcv_merge #(
      .DELAY_BITS(DELAY_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (v2),
      .in_value     (value2),
      .in_ref       (ref2),
      .out_strobe   (rsp_strobe),
      .out_voted    (rsp_voted_delay),
      .out_count    (rsp_agree_count),
      .out_saturated(rsp_saturated)
   );

endmodule

// ===== design/dcv_checker.sv =====
module dcv_checker
   import dcv_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic signed [Q8_BITS-1:0] rsp_voted_delay,
   input logic [1:0]                rsp_agree_count,
   input logic                      rsp_saturated
);

   a_resp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("request transaction without response");

   a_no_spurious_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start, LATENCY) && !$past(busy, LATENCY)))
      else $error("response transaction without request");

   a_sat_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |->
         (!rsp_voted_delay[Q8_BITS-1] && (rsp_voted_delay[7:0] == 8'd0)))
      else $error("saturated result is not a whole positive delay");

   a_single_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_agree_count == 2'd0)) |-> (rsp_voted_delay[7:0] == 8'd0))
      else $error("single-value result has a fraction");

endmodule

bind delay_consensus_vote dcv_checker u_dcv_checker (.*);
